// File: rtl/aph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aph_pkg
// Types, constants and modular reduction helpers shared by the AS path hash.
// ----------------------------------------------------------------------------
package aph_pkg;

	localparam int unsigned AsWidth   = 16;
	localparam int unsigned HashWidth = 16;

	localparam logic [HashWidth-1:0] HASH_MULT_INIT = 16'd31415;
	localparam logic [HashWidth-1:0] HASH_MULT_STEP = 16'd27183;
	localparam logic [16:0]          HASH_MODULUS   = 17'd65521;
	localparam logic [16:0]          MULT_MODULUS   = 17'd65520;

	typedef struct packed {
		logic [AsWidth-1:0] as_number;
		logic               has_value;
		logic               last_item;
	} aph_item_t;

	// x mod 65521, using 2^16 = 15 (mod 65521)
	function automatic logic [HashWidth-1:0] mod_hash(input logic [31:0] x);
		logic [20:0] t1;
		logic [16:0] t2;
		logic [16:0] t3;
		t1 = ({1'b0, x[31:16], 4'b0000} - {5'b00000, x[31:16]}) + {5'b00000, x[15:0]};
		t2 = ({8'd0, t1[20:16], 4'b0000} - {12'd0, t1[20:16]}) + {1'b0, t1[15:0]};
		t3 = (t2 >= HASH_MODULUS) ? (t2 - HASH_MODULUS) : t2;
		return t3[HashWidth-1:0];
	endfunction

	// x mod 65520, using 2^16 = 16 (mod 65520)
	function automatic logic [HashWidth-1:0] mod_mult(input logic [31:0] x);
		logic [20:0] t1;
		logic [16:0] t2;
		logic [16:0] t3;
		t1 = {1'b0, x[31:16], 4'b0000} + {5'b00000, x[15:0]};
		t2 = {8'd0, t1[20:16], 4'b0000} + {1'b0, t1[15:0]};
		t3 = (t2 >= MULT_MODULUS) ? (t2 - MULT_MODULUS) : t2;
		return t3[HashWidth-1:0];
	endfunction

endpackage

// File: rtl/as_path_universal_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// as_path_universal_hash
// Streaming universal hash over the 16-bit AS numbers of an AS path.
// ----------------------------------------------------------------------------
// Takes one AS number per cycle while in_ready is high and keeps a running
// hash (mod 65521) and a running multiplier (mod 65520, starting at 31415).
// A transaction marked last_item returns the hash of the whole path in the
// result register at the same edge that it leaves the input register, and
// clears the running state; a transaction with has_value low returns 0 and
// also clears it. Sustained rate is one item per clock while the input is
// not stalled, set by the multiply and modular fold on the running state;
// a result passes through the input register and then the result register.
// in_ready drops only while a finished hash waits in the result register
// with out_ready low and the input register holds another path end or
// empty marker.
module as_path_universal_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [aph_pkg::AsWidth-1:0]   as_number,
	input  logic                          has_value,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [aph_pkg::HashWidth-1:0] hash_value
);

	aph_pkg::aph_item_t            item_in;
	aph_pkg::aph_item_t            item_s1;
	logic                          valid_s1;
	logic                          emits;
	logic [aph_pkg::HashWidth-1:0] result_hash;
	logic                          out_free;
	logic                          advance;
	logic                          load_in;
	logic                          load_out;

	assign item_in = '{as_number: as_number, has_value: has_value, last_item: last_item};

	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!emits || out_free);
	assign in_ready = !valid_s1 || advance;
	assign load_in  = in_valid && in_ready;
	assign load_out = advance && emits;

	aph_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_in),
		.drain    (advance),
		.item     (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	aph_hash_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.emits       (emits),
		.result_hash (result_hash)
	);

	aph_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_out),
		.hash_in    (result_hash),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.hash_value (hash_value)
	);

`ifndef SYNTHESIS
	// the input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |-> (out_valid && !out_ready && emits))
		else $error("input stalled without a held result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid)
		else $error("result transaction lost");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !item_s1.has_value) |=> (hash_value == '0))
		else $error("empty path did not hash to zero");

	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, hash_value} < aph_pkg::HASH_MODULUS))
		else $error("hash out of range");
`endif

endmodule

// File: rtl/aph_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aph_in_stage
// Input register: captures one AS number transaction per cycle on load.
// ----------------------------------------------------------------------------
module aph_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              drain,
	input  aph_pkg::aph_item_t item,
	output logic              valid_s1,
	output aph_pkg::aph_item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// File: rtl/aph_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aph_hash_core
// Running hash and multiplier with the modular update applied on each step.
// ----------------------------------------------------------------------------
module aph_hash_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  aph_pkg::aph_item_t                item,
	output logic                              emits,
	output logic [aph_pkg::HashWidth-1:0]     result_hash
);

	logic [aph_pkg::HashWidth-1:0] hash_q;
	logic [aph_pkg::HashWidth-1:0] mult_q;
	logic [31:0]                   hash_prod;
	logic [31:0]                   mult_prod;
	logic [aph_pkg::HashWidth-1:0] hash_next;
	logic [aph_pkg::HashWidth-1:0] mult_next;

	always_comb begin
		hash_prod = ({16'd0, mult_q} * {16'd0, hash_q}) + {16'd0, item.as_number};
		mult_prod = {16'd0, mult_q} * {16'd0, aph_pkg::HASH_MULT_STEP};
		hash_next = aph_pkg::mod_hash(hash_prod);
		mult_next = aph_pkg::mod_mult(mult_prod);
	end

	// empty marker always answers, and answers zero
	assign emits       = !item.has_value || item.last_item;
	assign result_hash = item.has_value ? hash_next : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			mult_q <= aph_pkg::HASH_MULT_INIT;
		end else if (step) begin
			if (emits) begin
				hash_q <= '0;
				mult_q <= aph_pkg::HASH_MULT_INIT;
			end else begin
				hash_q <= hash_next;
				mult_q <= mult_next;
			end
		end
	end

endmodule

// File: rtl/aph_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aph_out_stage
// Result register holding one hash until the downstream side takes it.
// ----------------------------------------------------------------------------
module aph_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [aph_pkg::HashWidth-1:0] hash_in,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [aph_pkg::HashWidth-1:0] hash_value
);

	logic                          valid_q;
	logic [aph_pkg::HashWidth-1:0] hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hash_q <= hash_in;
		end
	end

	assign out_valid  = valid_q;
	assign hash_value = hash_q;

endmodule

// File: dv/as_path_universal_hash_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// as_path_universal_hash_test
// Self-checking bench for the streaming AS path hash.
// ----------------------------------------------------------------------------
// A directed table covers the corner cases first: single-number paths at the
// field extremes, empty markers with and without last_item, and a marker that
// cuts a path short. Random paths with random content follow, mixed with
// stray empty markers. Both handshakes see random gaps. Every result is
// compared in order with the table value or a bit-accurate hash model here.
// ----------------------------------------------------------------------------
module as_path_universal_hash_test;

	localparam int unsigned AsWidth     = aph_pkg::AsWidth;
	localparam int unsigned HashWidth   = aph_pkg::HashWidth;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RAND_ITEMS  = 1425;
	localparam int unsigned DRAIN_EVERY = 300;
	localparam int unsigned MAX_PRINTS  = 40;

	typedef struct packed {
		logic [AsWidth-1:0]   as_num;
		logic                 has;
		logic                 last;
		logic                 known;
		logic [HashWidth-1:0] known_hash;
	} stim_row_t;

	// rows marked known are empty markers or start from a cleared path state
	localparam int unsigned DIR_ROWS = 25;
	localparam stim_row_t dir_table [DIR_ROWS] = '{
		'{16'd0,     1'b1, 1'b1, 1'b1, 16'd0},
		'{16'd65535, 1'b1, 1'b1, 1'b1, 16'd14},
		'{16'd65520, 1'b1, 1'b1, 1'b1, 16'd65520},
		'{16'd65521, 1'b1, 1'b1, 1'b1, 16'd0},
		'{16'd1234,  1'b0, 1'b0, 1'b1, 16'd0},
		'{16'd65535, 1'b0, 1'b1, 1'b1, 16'd0},
		'{16'd1,     1'b1, 1'b1, 1'b1, 16'd1},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd0,     1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 1'b1, 1'b1, 1'b0, 16'd0},
		'{16'd100,   1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd43210, 1'b0, 1'b0, 1'b1, 16'd0},
		'{16'd7,     1'b1, 1'b1, 1'b1, 16'd7},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd0,     1'b0, 1'b1, 1'b1, 16'd0},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65520, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65521, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 1'b1, 1'b1, 1'b0, 16'd0},
		'{16'd32768, 1'b1, 1'b1, 1'b1, 16'd32768},
		'{16'd21845, 1'b1, 1'b0, 1'b0, 16'd0}
	};

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [AsWidth-1:0]   as_number  = '0;
	logic                 has_value  = 1'b0;
	logic                 last_item  = 1'b0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [HashWidth-1:0] hash_value;

	// model state of the path in progress
	logic [HashWidth-1:0] run_hash = '0;
	logic [HashWidth-1:0] path_mult = aph_pkg::HASH_MULT_INIT;

	logic [HashWidth-1:0] pending_hash [$];
	int unsigned          err_count   = 0;
	int unsigned          items_sent  = 0;
	int unsigned          cycle_count = 0;
	int unsigned          stall_left  = 0;
	bit                   calm        = 1'b0;

	as_path_universal_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.as_number  (as_number),
		.has_value  (has_value),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("as_path_universal_hash verification failed");
			$finish;
		end
	end

	// advances the path state by one number, returns 1 when a hash comes out
	function automatic bit hash_step(input logic [AsWidth-1:0] as_in, input logic has_in,
			input logic last_in, output logic [HashWidth-1:0] hash_out);
		logic [63:0] acc;
		logic [63:0] next_mult;
		hash_out = '0;
		if (!has_in) begin
			run_hash = '0;
			path_mult = aph_pkg::HASH_MULT_INIT;
			return 1'b1;
		end
		acc = {48'd0, path_mult} * {48'd0, run_hash} + {48'd0, as_in};
		next_mult = {48'd0, path_mult} * {48'd0, aph_pkg::HASH_MULT_STEP};
		run_hash = HashWidth'(acc % {47'd0, aph_pkg::HASH_MODULUS});
		path_mult = HashWidth'(next_mult % {47'd0, aph_pkg::MULT_MODULUS});
		if (last_in) begin
			hash_out = run_hash;
			run_hash = '0;
			path_mult = aph_pkg::HASH_MULT_INIT;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [AsWidth-1:0] pick_as();
		if ($urandom_range(0, 99) >= 20)
			return AsWidth'($urandom);
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'd65520;
			3: return 16'd65521;
			4: return 16'd65534;
			default: return 16'd65535;
		endcase
	endfunction

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(7, 30);
		return $urandom_range(31, 120);
	endfunction

	task automatic report_mismatch(input string what, input logic [HashWidth-1:0] got,
			input logic [HashWidth-1:0] want);
		if (err_count < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s, got %0d want %0d", cycle_count, what, got, want);
		err_count++;
	endtask

	task automatic drive_item(input logic [AsWidth-1:0] as_in, input logic has_in,
			input logic last_in, input logic known_in, input logic [HashWidth-1:0] known_val);
		int unsigned          gap;
		logic [HashWidth-1:0] predicted;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		as_number <= as_in;
		has_value <= has_in;
		last_item <= last_in;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (hash_step(as_in, has_in, last_in, predicted))
			pending_hash.push_back(known_in ? known_val : predicted);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_hash.size() != 0);
	endtask

	task automatic run_random(input int unsigned n_items);
		int unsigned target;
		int unsigned next_drain;
		int unsigned plen;
		target = items_sent + n_items;
		next_drain = items_sent + DRAIN_EVERY;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 5)
				calm = ~calm;
			if (items_sent >= next_drain) begin
				drain_results();
				next_drain += DRAIN_EVERY;
			end
			if ($urandom_range(0, 99) < 8) begin
				drive_item(AsWidth'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
			end else begin
				plen = pick_len();
				for (int unsigned k = 0; k < plen; k++) begin
					// a marker here abandons the partial path
					if ($urandom_range(0, 99) < 3)
						drive_item(AsWidth'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
					drive_item(pick_as(), 1'b1, k == plen - 1, 1'b0, '0);
				end
			end
		end
	endtask

	// result side: check each transaction, then pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_hash.size() == 0)
					report_mismatch("result with nothing pending", hash_value, '0);
				else if (hash_value !== pending_hash[0])
					report_mismatch("hash_value", hash_value, pending_hash[0]);
				if (pending_hash.size() != 0)
					void'(pending_hash.pop_front());
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int unsigned i = 0; i < DIR_ROWS; i++)
			drive_item(dir_table[i].as_num, dir_table[i].has, dir_table[i].last,
				dir_table[i].known, dir_table[i].known_hash);
		drain_results();
		run_random(RAND_ITEMS);
		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_hash.size() == 0) begin
			$display("as_path_universal_hash verification clean");
		end else begin
			$display("as_path_universal_hash verification failed");
		end
		$finish;
	end

endmodule

// File: as_path_universal_hash.f
rtl/aph_pkg.sv
rtl/aph_in_stage.sv
rtl/aph_hash_core.sv
rtl/aph_out_stage.sv
rtl/as_path_universal_hash.sv
dv/as_path_universal_hash_test.sv
